@@ sv/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    // per-transaction control broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } sst_cell_ctl_t;

endpackage

@@ sv/sst_req_if.sv @@
// ----------------------------------------------------------------------------
// sst_req_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface sst_req_if;
    import sst_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

@@ sv/sst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sst_rsp_if
// Response channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface sst_rsp_if;
    import sst_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] found_position;
    logic [POS_W-1:0] count;
    logic [1:0]       status;

    modport source (output valid, output found, output found_position, output count,
                    output status, input ready);
    modport sink   (input valid, input found, input found_position, input count,
                    input status, output ready);
endinterface

@@ sv/sst_cell.sv @@
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted table: holds an entry, compares it with the
// request value and shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sst_cell
    import sst_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic                      clk,
    input  sst_cell_ctl_t             ctl,
    input  logic [CNT_W-1:0]          count,
    input  logic                      left_shift,
    input  logic signed [VALUE_W-1:0] left_entry,
    input  logic signed [VALUE_W-1:0] right_entry,
    output logic signed [VALUE_W-1:0] entry,
    output logic                      shift,
    output logic                      match
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      occupied;
    logic                      at_end;
    logic                      rem_take;

    assign occupied = CNT_W'(IDX) < count;
    assign at_end   = count == CNT_W'(IDX);
    assign shift    = occupied && (entry_reg > ctl.value);
    assign match    = occupied && (entry_reg == ctl.value);
    // cells at or after the removed slot pull from the right
    assign rem_take = CMP_W'(IDX + 1) >= CMP_W'(ctl.position);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (left_shift)
                entry_next = left_entry;
            else if (shift || at_end)
                entry_next = ctl.value;
        end
        else if (ctl.rem && rem_take)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ sv/sorted_set_table.sv @@
// ----------------------------------------------------------------------------
// sorted_set_table
// Set of distinct signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Every request (insert, lookup, remove at position, clear) gives one
// registered response in the cycle after it is taken; a new request is taken
// in the same cycle the previous response leaves, so the table sustains one
// request per cycle while responses are taken. The table is a row of
// CAPACITY cells, each comparing its entry with the request value and
// shifting with its neighbors, so insert and remove finish on accept.
// Entries past the count are never read and need no clearing after reset.
module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    sst_req_if.sink  req,
    sst_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      found_reg;
    logic [POS_W-1:0]          fpos_reg;
    logic [POS_W-1:0]          cnt_out_reg;
    status_t                   status_reg;

    logic                      accept;
    logic                      dup;
    logic                      full;
    logic                      pos_ok;
    logic                      found_c;
    logic [POS_W-1:0]          fpos_c;
    status_t                   status_c;
    sst_cell_ctl_t             ctl;

    logic [CAPACITY-1:0]       shift_v;
    logic [CAPACITY-1:0]       match_v;
    logic signed [VALUE_W-1:0] entry_v [CAPACITY];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign dup    = |match_v;
    assign full   = count_reg == CNT_W'(CAPACITY);
    assign pos_ok = (req.position != '0)
                    && (CMP_W'(req.position) <= CMP_W'(count_reg));

    always_comb
    begin
        fpos_c = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_v[i])
                fpos_c = fpos_c | POS_W'(i + 1);
        end
    end

    always_comb
    begin
        ctl.ins      = 1'b0;
        ctl.rem      = 1'b0;
        ctl.value    = req.value;
        ctl.position = req.position;
        count_next   = count_reg;
        found_c      = 1'b0;
        status_c     = ST_OK;
        unique case (req_kind_t'(req.req_type))
            REQ_INSERT:
            begin
                if (dup)
                    status_c = ST_DUP;
                else if (full)
                    status_c = ST_FULL;
                else
                begin
                    ctl.ins    = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_LOOKUP:
            begin
                found_c = dup;
            end
            REQ_REMOVE:
            begin
                if (!pos_ok)
                    status_c = ST_BAD_POS;
                else
                begin
                    ctl.rem    = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                      l_shift;
            logic signed [VALUE_W-1:0] l_entry;
            logic signed [VALUE_W-1:0] r_entry;

            if (g == 0)
            begin : g_first
                assign l_shift = 1'b0;
                assign l_entry = req.value;
            end
            else
            begin : g_mid
                assign l_shift = shift_v[g-1];
                assign l_entry = entry_v[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign r_entry = entry_v[g];
            end
            else
            begin : g_inner
                assign r_entry = entry_v[g+1];
            end

            sst_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .count       (count_reg),
                .left_shift  (l_shift),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .entry       (entry_v[g]),
                .shift       (shift_v[g]),
                .match       (match_v[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg   <= found_c;
            fpos_reg    <= found_c ? fpos_c : '0;
            cnt_out_reg <= POS_W'(count_next);
            status_reg  <= status_c;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.found          = found_reg;
    assign rsp.found_position = fpos_reg;
    assign rsp.count          = cnt_out_reg;
    assign rsp.status         = status_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks sorted_set_table against a shadow copy of the ordered set. Requests
// are inserts, lookups, removes and clears. A short directed run covers
// empty and full tables, duplicates, the value extremes and bad positions.
// Random traffic then runs under four handshake pressure phases. Every
// response is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module tb;
    import sst_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int STALL_MAX  = 4000;
    localparam int RAND_ITEMS = 300;
    localparam int POOL_SIZE  = 20;

    typedef struct {
        req_kind_t                 kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } set_req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] count;
        status_t          status;
    } set_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sst_req_if req_if ();
    sst_rsp_if rsp_if ();

    sorted_set_table #(.CAPACITY(CAPACITY)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // shadow of the table contents
    logic signed [VALUE_W-1:0] shadow_vals [CAPACITY];
    int                        shadow_count = 0;

    set_req_t  pending_reqs [$];
    set_rsp_t  awaited_results [$];
    logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    // applies one request to the shadow set and returns the response it gives
    function automatic set_rsp_t set_response(set_req_t q);
        set_rsp_t r;
        int       at;
        bit       dup;
        r = '0;
        r.status = ST_OK;
        case (q.kind)
            REQ_INSERT:
            begin
                dup = 1'b0;
                at  = shadow_count;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_vals[i] == q.value)
                        dup = 1'b1;
                    if (shadow_vals[i] > q.value && at == shadow_count)
                        at = i;
                end
                if (dup)
                    r.status = ST_DUP;
                else if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int k = shadow_count; k > at; k--)
                        shadow_vals[k] = shadow_vals[k-1];
                    shadow_vals[at] = q.value;
                    shadow_count++;
                end
            end
            REQ_LOOKUP:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (!r.found && shadow_vals[i] == q.value)
                    begin
                        r.found          = 1'b1;
                        r.found_position = POS_W'(i + 1);
                    end
                end
            end
            REQ_REMOVE:
            begin
                if (q.position == 0 || q.position > shadow_count)
                    r.status = ST_BAD_POS;
                else
                begin
                    for (int k = q.position - 1; k + 1 < shadow_count; k++)
                        shadow_vals[k] = shadow_vals[k+1];
                    shadow_count--;
                end
            end
            default:
                shadow_count = 0;
        endcase
        r.count = POS_W'(shadow_count);
        return r;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic queue_request(req_kind_t kind, logic signed [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] position);
        set_req_t q;
        q.kind     = kind;
        q.value    = value;
        q.position = position;
        pending_reqs.push_back(q);
    endtask

    // mostly pool values so duplicates and hits are common
    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 55)
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        set_req_t acc;
        set_req_t nxt;
        if (!rst_n)
        begin
            req_if.valid    <= 1'b0;
            req_if.req_type <= REQ_CLEAR;
            req_if.value    <= '0;
            req_if.position <= '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                acc.kind     = req_kind_t'(req_if.req_type);
                acc.value    = req_if.value;
                acc.position = req_if.position;
                awaited_results.push_back(set_response(acc));
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.req_type <= nxt.kind;
                    req_if.value    <= nxt.value;
                    req_if.position <= nxt.position;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin : check_responses
        set_rsp_t want;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (awaited_results.size() == 0)
                    note_failure("response with no request outstanding");
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_if.found !== want.found ||
                        rsp_if.found_position !== want.found_position ||
                        rsp_if.count !== want.count || rsp_if.status !== want.status)
                        note_failure($sformatf(
                            {"found %0b/%0b found_position %0d/%0d count %0d/%0d ",
                             "status %0d/%0d (expected/actual)"},
                            want.found, rsp_if.found, want.found_position,
                            rsp_if.found_position, want.count, rsp_if.count,
                            want.status, rsp_if.status));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int       pick;
        int       idle_sets [4];
        int       stall_sets [4];
        req_kind_t kind;
        idle_sets  = '{0, 46, 0, 37};
        stall_sets = '{0, 0, 46, 37};

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, extremes, duplicates, bad positions
        queue_request(REQ_LOOKUP, 0, 0);
        queue_request(REQ_REMOVE, 0, 1);
        queue_request(REQ_INSERT, 0, 0);
        queue_request(REQ_INSERT, 32'sh7FFF_FFFF, 0);
        queue_request(REQ_INSERT, 32'sh8000_0000, 0);
        queue_request(REQ_INSERT, -1, 0);
        queue_request(REQ_INSERT, 0, 0);
        queue_request(REQ_LOOKUP, 32'sh8000_0000, 0);
        queue_request(REQ_LOOKUP, 32'sh7FFF_FFFF, 0);
        queue_request(REQ_LOOKUP, 12345, 0);
        queue_request(REQ_REMOVE, 0, 0);
        queue_request(REQ_REMOVE, 0, 5);
        queue_request(REQ_REMOVE, 0, 4);
        queue_request(REQ_REMOVE, 0, 1);
        queue_request(REQ_CLEAR, 0, 0);
        queue_request(REQ_CLEAR, -1, 31);
        // fill to capacity, each insert landing at the front
        for (int i = 0; i < CAPACITY; i++)
            queue_request(REQ_INSERT, 1000 - i * 97, 0);
        queue_request(REQ_INSERT, 5000, 0);
        queue_request(REQ_INSERT, 1000, 0);
        queue_request(REQ_LOOKUP, 1000, 0);
        queue_request(REQ_REMOVE, 0, 16);
        queue_request(REQ_REMOVE, 0, 1);
        queue_request(REQ_CLEAR, 0, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            // hold the sender until the table has answered everything
            while (pending_reqs.size() != 0 || req_if.valid || awaited_results.size() != 0)
                @(posedge clk);
            send_idle_pct = idle_sets[ph];
            rsp_stall_pct = stall_sets[ph];
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    kind = REQ_INSERT;
                else if (pick < 77)
                    kind = REQ_LOOKUP;
                else if (pick < 98)
                    kind = REQ_REMOVE;
                else
                    kind = REQ_CLEAR;
                queue_request(kind, pick_value(), POS_W'($urandom_range(16)));
            end
        end

        while (pending_reqs.size() != 0 || req_if.valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (awaited_results.size() != 0)
            note_failure("responses still outstanding at end of run");

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
